### sv/private_timer_watchdog_core_assert.svh
// Assertion macros shared by the private timer and watchdog RTL.
`ifndef PRIVATE_TIMER_WATCHDOG_CORE_ASSERT_SVH
`define PRIVATE_TIMER_WATCHDOG_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTWD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("private timer watchdog assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PTWD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("private timer watchdog assertion failed");

`endif

### sv/ptwd_pkg.sv
// Types and constants shared by the private timer and watchdog modules.
`default_nettype none

package ptwd_pkg;

    typedef struct packed {
        logic wdmode;
        logic inten;
        logic reload;
        logic enable;
    } ctl_t;

    localparam int CTL_BITS      = 4;
    localparam int CTL_PRESC_LSB = 8;
    localparam int DATA_WIDTH    = 32;
    localparam int USER_WIDTH    = 8;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [2:0] OFF_LOAD    = 3'd0;
    localparam logic [2:0] OFF_COUNT   = 3'd1;
    localparam logic [2:0] OFF_CONTROL = 3'd2;
    localparam logic [2:0] OFF_EVENT   = 3'd3;
    localparam logic [2:0] OFF_RESET   = 3'd4;
    localparam logic [2:0] OFF_DISABLE = 3'd5;

    localparam logic [31:0] WD_KEY1 = 32'h1234_5678;
    localparam logic [31:0] WD_KEY2 = 32'h8765_4321;

endpackage

`default_nettype wire

### sv/ptwd_unit_tick.sv
// Prescaler and down-counter step for one timer unit on a clock tick.
`default_nettype none

module ptwd_unit_tick #(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 8
) (
    input  wire logic                      tick,
    input  wire ptwd_pkg::ctl_t            ctl,
    input  wire logic [PRESCALE_WIDTH-1:0] limit,
    input  wire logic [PRESCALE_WIDTH-1:0] presc,
    input  wire logic [COUNT_WIDTH-1:0]    cnt,
    input  wire logic [COUNT_WIDTH-1:0]    load,
    output logic      [PRESCALE_WIDTH-1:0] presc_next,
    output logic      [COUNT_WIDTH-1:0]    cnt_next,
    output logic                           expire
);

    logic reload_en;

    always_comb begin
        reload_en  = ctl.reload && !ctl.wdmode;
        presc_next = presc;
        cnt_next   = cnt;
        expire     = 1'b0;
        if (tick && ctl.enable) begin
            if (presc < limit) begin
                presc_next = presc + 1'b1;
            end else begin
                presc_next = '0;
                if (cnt != '0) begin
                    cnt_next = cnt - 1'b1;
                    expire   = (cnt == COUNT_WIDTH'(1));
                end else if (reload_en) begin
                    cnt_next = load;
                    expire   = (load == '0);
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/private_timer_watchdog_core.sv
// Top level of the private timer and watchdog with its register bank and stream ports.
`default_nettype none

`include "private_timer_watchdog_core_assert.svh"

// Every input beat is a register read, a register write or one clock tick for
// both units, and it produces exactly one result beat carrying the read data
// and the interrupt and reset flags as they stand after that beat. The core
// takes one beat per cycle while the output is not stalled: a beat goes into
// an input register, all register and counter updates happen in combinational
// logic, and the result lands in an output register. A stalled output holds
// the pipeline; the input side takes a beat whenever the input register is
// empty or its beat moves on to an output register that is free or being emptied.
module private_timer_watchdog_core #(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // wdata
    input  wire logic [31:0] s_axis_tdata,
    // cmd[1:0], unit[2], reg_offset[5:3], zero[7:6]
    input  wire logic [7:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // rdata
    output logic      [31:0] m_axis_tdata,
    // timer_irq[0], wdog_irq[1], wdog_reset[2], zero[7:3]
    output logic      [7:0]  m_axis_tuser
);

    localparam int PAD_BITS = ptwd_pkg::USER_WIDTH - 3;

    logic                      in_valid_reg;
    logic [1:0]                in_cmd_reg;
    logic                      in_unit_reg;
    logic [2:0]                in_off_reg;
    logic [31:0]               in_wdata_reg;
    logic                      advance;

    logic [COUNT_WIDTH-1:0]    tload_reg, tload_next, tcnt_reg, tcnt_next;
    ptwd_pkg::ctl_t            tctl_reg, tctl_next;
    logic [PRESCALE_WIDTH-1:0] tlim_reg, tlim_next, tpsc_reg, tpsc_next;
    logic                      tev_reg, tev_next;
    logic [COUNT_WIDTH-1:0]    wload_reg, wload_next, wcnt_reg, wcnt_next;
    ptwd_pkg::ctl_t            wctl_reg, wctl_next;
    logic [PRESCALE_WIDTH-1:0] wlim_reg, wlim_next, wpsc_reg, wpsc_next;
    logic                      wev_reg, wev_next, wrst_reg, wrst_next;
    logic                      dseq_reg, dseq_next;

    logic                      m_valid_reg;
    logic [31:0]               m_data_reg, m_data_next;
    logic [7:0]                m_user_reg, m_user_next;

    logic [COUNT_WIDTH-1:0]    t_cnt_tick, w_cnt_tick;
    logic [PRESCALE_WIDTH-1:0] t_psc_tick, w_psc_tick;
    logic                      t_expire, w_expire, is_tick;
    logic [31:0]               t_ctl_rd, w_ctl_rd;

    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign is_tick       = (in_cmd_reg == ptwd_pkg::CMD_TICK);

    ptwd_unit_tick #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .PRESCALE_WIDTH(PRESCALE_WIDTH)
    ) u_timer_tick (
        .tick      (is_tick),
        .ctl       (tctl_reg),
        .limit     (tlim_reg),
        .presc     (tpsc_reg),
        .cnt       (tcnt_reg),
        .load      (tload_reg),
        .presc_next(t_psc_tick),
        .cnt_next  (t_cnt_tick),
        .expire    (t_expire)
    );

    ptwd_unit_tick #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .PRESCALE_WIDTH(PRESCALE_WIDTH)
    ) u_wdog_tick (
        .tick      (is_tick),
        .ctl       (wctl_reg),
        .limit     (wlim_reg),
        .presc     (wpsc_reg),
        .cnt       (wcnt_reg),
        .load      (wload_reg),
        .presc_next(w_psc_tick),
        .cnt_next  (w_cnt_tick),
        .expire    (w_expire)
    );

    assign t_ctl_rd = 32'(tctl_reg) | (32'(tlim_reg) << ptwd_pkg::CTL_PRESC_LSB);
    assign w_ctl_rd = 32'(wctl_reg) | (32'(wlim_reg) << ptwd_pkg::CTL_PRESC_LSB);

    always_comb begin
        tload_next  = tload_reg;
        tcnt_next   = tcnt_reg;
        tctl_next   = tctl_reg;
        tlim_next   = tlim_reg;
        tpsc_next   = tpsc_reg;
        tev_next    = tev_reg;
        wload_next  = wload_reg;
        wcnt_next   = wcnt_reg;
        wctl_next   = wctl_reg;
        wlim_next   = wlim_reg;
        wpsc_next   = wpsc_reg;
        wev_next    = wev_reg;
        wrst_next   = wrst_reg;
        dseq_next   = dseq_reg;
        m_data_next = '0;
        unique case (in_cmd_reg)
            ptwd_pkg::CMD_READ: begin
                if (!in_unit_reg) begin
                    unique case (in_off_reg)
                        ptwd_pkg::OFF_LOAD:    m_data_next = 32'(tload_reg);
                        ptwd_pkg::OFF_COUNT:   m_data_next = 32'(tcnt_reg);
                        ptwd_pkg::OFF_CONTROL: m_data_next = t_ctl_rd;
                        ptwd_pkg::OFF_EVENT:   m_data_next = 32'(tev_reg);
                        default:               m_data_next = '0;
                    endcase
                end else begin
                    unique case (in_off_reg)
                        ptwd_pkg::OFF_LOAD:    m_data_next = 32'(wload_reg);
                        ptwd_pkg::OFF_COUNT:   m_data_next = 32'(wcnt_reg);
                        ptwd_pkg::OFF_CONTROL: m_data_next = w_ctl_rd;
                        ptwd_pkg::OFF_EVENT:   m_data_next = 32'(wev_reg);
                        ptwd_pkg::OFF_RESET:   m_data_next = 32'(wrst_reg);
                        default:               m_data_next = '0;
                    endcase
                end
            end
            ptwd_pkg::CMD_WRITE: begin
                if (!in_unit_reg) begin
                    unique case (in_off_reg)
                        ptwd_pkg::OFF_LOAD: begin
                            tload_next = in_wdata_reg[COUNT_WIDTH-1:0];
                            tcnt_next  = in_wdata_reg[COUNT_WIDTH-1:0];
                        end
                        ptwd_pkg::OFF_COUNT: begin
                            tcnt_next = in_wdata_reg[COUNT_WIDTH-1:0];
                        end
                        ptwd_pkg::OFF_CONTROL: begin
                            tctl_next        = ptwd_pkg::ctl_t'(in_wdata_reg[ptwd_pkg::CTL_BITS-1:0]);
                            tctl_next.wdmode = 1'b0;
                            tlim_next = in_wdata_reg[ptwd_pkg::CTL_PRESC_LSB +: PRESCALE_WIDTH];
                        end
                        ptwd_pkg::OFF_EVENT: begin
                            if (in_wdata_reg[0]) begin
                                tev_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (in_off_reg)
                        ptwd_pkg::OFF_LOAD: begin
                            wload_next = in_wdata_reg[COUNT_WIDTH-1:0];
                            wcnt_next  = in_wdata_reg[COUNT_WIDTH-1:0];
                        end
                        ptwd_pkg::OFF_COUNT: begin
                            wcnt_next = in_wdata_reg[COUNT_WIDTH-1:0];
                        end
                        ptwd_pkg::OFF_CONTROL: begin
                            wctl_next        = ptwd_pkg::ctl_t'(in_wdata_reg[ptwd_pkg::CTL_BITS-1:0]);
                            wctl_next.wdmode = in_wdata_reg[3] || wctl_reg.wdmode;
                            wlim_next = in_wdata_reg[ptwd_pkg::CTL_PRESC_LSB +: PRESCALE_WIDTH];
                        end
                        ptwd_pkg::OFF_EVENT: begin
                            if (in_wdata_reg[0]) begin
                                wev_next = 1'b0;
                            end
                        end
                        ptwd_pkg::OFF_RESET: begin
                            if (in_wdata_reg[0]) begin
                                wrst_next = 1'b0;
                            end
                        end
                        ptwd_pkg::OFF_DISABLE: begin
                            if (dseq_reg && in_wdata_reg == ptwd_pkg::WD_KEY2) begin
                                wctl_next.wdmode = 1'b0;
                                dseq_next        = 1'b0;
                            end else begin
                                dseq_next = (in_wdata_reg == ptwd_pkg::WD_KEY1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ptwd_pkg::CMD_TICK: begin
                tcnt_next = t_cnt_tick;
                tpsc_next = t_psc_tick;
                wcnt_next = w_cnt_tick;
                wpsc_next = w_psc_tick;
                if (t_expire) begin
                    tev_next = 1'b1;
                end
                if (w_expire) begin
                    if (wctl_reg.wdmode) begin
                        wrst_next = 1'b1;
                    end else begin
                        wev_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        m_user_next = {PAD_BITS'(0), wrst_next,
                       wev_next && wctl_next.inten && !wctl_next.wdmode,
                       tev_next && tctl_next.inten};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            tload_reg    <= '0;
            tcnt_reg     <= '0;
            tctl_reg     <= '0;
            tlim_reg     <= '0;
            tpsc_reg     <= '0;
            tev_reg      <= 1'b0;
            wload_reg    <= '0;
            wcnt_reg     <= '0;
            wctl_reg     <= '0;
            wlim_reg     <= '0;
            wpsc_reg     <= '0;
            wev_reg      <= 1'b0;
            wrst_reg     <= 1'b0;
            dseq_reg     <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                tload_reg <= tload_next;
                tcnt_reg  <= tcnt_next;
                tctl_reg  <= tctl_next;
                tlim_reg  <= tlim_next;
                tpsc_reg  <= tpsc_next;
                tev_reg   <= tev_next;
                wload_reg <= wload_next;
                wcnt_reg  <= wcnt_next;
                wctl_reg  <= wctl_next;
                wlim_reg  <= wlim_next;
                wpsc_reg  <= wpsc_next;
                wev_reg   <= wev_next;
                wrst_reg  <= wrst_next;
                dseq_reg  <= dseq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg   <= s_axis_tuser[1:0];
            in_unit_reg  <= s_axis_tuser[2];
            in_off_reg   <= s_axis_tuser[5:3];
            in_wdata_reg <= s_axis_tdata;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    // Counters and flags change only when a beat is processed.
    `PTWD_ASSERT_NEXT(a_state_holds, aclk, aresetn, !advance,
        $stable(tcnt_reg) && $stable(wcnt_reg) && $stable(wrst_reg) && $stable(tev_reg))

    // Watchdog mode is left only through the second key of the disable sequence.
    `PTWD_ASSERT_NEXT(a_wdmode_exit, aclk, aresetn,
        wctl_reg.wdmode && !(advance && in_cmd_reg == ptwd_pkg::CMD_WRITE && in_unit_reg
            && in_off_reg == ptwd_pkg::OFF_DISABLE && in_wdata_reg == ptwd_pkg::WD_KEY2),
        wctl_reg.wdmode)

    // A fresh result carries the timer interrupt and watchdog reset flags of the state it left behind.
    `PTWD_ASSERT_NEXT(a_result_flags, aclk, aresetn, advance,
        m_axis_tuser[0] == (tev_reg && tctl_reg.inten) && m_axis_tuser[2] == wrst_reg)

endmodule

`default_nettype wire
